>>> rtl/tcw_pkg.sv
package tcw_pkg;

	localparam int ROWS   = 25;
	localparam int COLS   = 80;
	localparam int NCELLS = ROWS * COLS;

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int CELL_W = $clog2(NCELLS);

	// item field widths
	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int VAL_W  = 16;
	localparam int CROW_W = 5;
	localparam int CCOL_W = 7;
	localparam int ATTR_W = 8;

	localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUT   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef struct packed {
		logic accept;
		logic put_exec;
		logic sweep_start;
		logic sweep_copy;
		logic home;
		logic rd_issue;
		logic out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic sweep_busy;
		logic scroll_need;
		logic out_free;
	} tcw_stat_t;

endpackage

>>> rtl/tcw_ifs.sv
interface tcw_req_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, req_type, char_code, cell_index, input ready);
	modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  cell_value;
	logic [CROW_W-1:0] cursor_row;
	logic [CCOL_W-1:0] cursor_col;
	logic              scrolled;

	modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, input ready);
	modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, output ready);
endinterface

>>> rtl/text_console_writer_core.sv
// Text console, 25 x 80 cells of attribute and glyph, with cursor.
// Clear and a scrolling put sweep the cell memory one cell per cycle. One item at
// a time; a new item is taken while the previous result waits in the output register.
// Reset: cursor homed, attribute 7; a blanking pass over all 2000 cells holds
// input ready low until it ends.
module text_console_writer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	tcw_req_if.sink                    req,
	tcw_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
	import tcw_pkg::*;

	tcw_cmd_t  cmd;
	tcw_stat_t stat;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.req_type (req_t'(req.req_type)),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req.req_type),
		.char_code  (req.char_code),
		.cell_index (req.cell_index),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.cell_value (rsp.cell_value),
		.cursor_row (rsp.cursor_row),
		.cursor_col (rsp.cursor_col),
		.scrolled   (rsp.scrolled)
	);

	// no item is taken while a sweep owns the memory
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && stat.sweep_busy))
		else $error("input ready during cell sweep");

	// a scroll always leaves the cursor at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.scrolled) |->
		(rsp.cursor_row == CROW_W'(ROWS - 1) && rsp.cursor_col == '0))
		else $error("scrolled result with cursor off last row start");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (32'(rsp.cursor_col) < COLS && 32'(rsp.cursor_row) < ROWS))
		else $error("cursor out of range");

endmodule

>>> rtl/tcw_ctrl.sv
module tcw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcw_pkg::req_t     req_type,
	input  tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_cmd_t cmd
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_INIT: begin
				if (!stat.sweep_busy)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (req_type)
						REQ_PUT:  state_d = ST_PUT;
						REQ_READ: state_d = ST_READ;
						REQ_CLEAR: begin
							cmd.sweep_start = 1'b1;
							cmd.home        = 1'b1;
							state_d         = ST_SWEEP;
						end
						default:  state_d = ST_FINISH;
					endcase
				end
			end
			ST_PUT: begin
				cmd.put_exec = 1'b1;
				if (stat.scroll_need) begin
					cmd.sweep_start = 1'b1;
					cmd.sweep_copy  = 1'b1;
					state_d         = ST_SWEEP;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_SWEEP: begin
				if (!stat.sweep_busy)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/tcw_dp.sv
module tcw_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcw_pkg::tcw_cmd_t            cmd,
	output tcw_pkg::tcw_stat_t           stat,
	input  logic                         cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]   cfg_wdata,
	input  logic [tcw_pkg::REQ_W-1:0]    req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcw_pkg::IDX_W-1:0]    cell_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tcw_pkg::VAL_W-1:0]    cell_value,
	output logic [tcw_pkg::CROW_W-1:0]   cursor_row,
	output logic [tcw_pkg::CCOL_W-1:0]   cursor_col,
	output logic                         scrolled
);
	import tcw_pkg::*;

	logic [VAL_W-1:0]  mem [NCELLS];

	logic [ATTR_W-1:0] attr_q;
	req_t              req_q;
	logic [CHAR_W-1:0] ch_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              scrolled_q;

	logic              sweep_act_q;
	logic              sweep_init_q;
	logic              sweep_copy_q;
	logic [CELL_W-1:0] cnt_q;
	logic              wr_s1;
	logic              copy_s1;
	logic [CELL_W-1:0] dest_s1;
	logic [VAL_W-1:0]  rdata_q;
	logic              out_valid_q;

	logic [VAL_W-1:0]  blank_attr;
	logic [VAL_W-1:0]  blank_sweep;
	logic              cnt_copy;
	logic [CELL_W:0]   src;
	logic              idx_ok;
	logic              rd_en;
	logic [CELL_W-1:0] raddr;
	logic              we;
	logic [CELL_W-1:0] waddr;
	logic [VAL_W-1:0]  wdata;

	logic [COL_W:0]    col_n;
	logic [ROW_W:0]    row_n;
	logic [COL_W-1:0]  wcol;
	logic              put_we;
	logic [VAL_W-1:0]  put_data;
	logic [CELL_W-1:0] put_addr;
	logic              scroll_need;

	assign blank_attr  = {attr_q, CH_SPACE};
	assign blank_sweep = sweep_init_q ? {ATTR_RESET, CH_SPACE} : blank_attr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_t'(req_type);
			ch_q  <= char_code;
			idx_q <= cell_index;
		end
	end

	// put: next cursor and the cell written, if any
	always_comb begin
		col_n    = {1'b0, col_q};
		row_n    = {1'b0, row_q};
		wcol     = col_q;
		put_we   = 1'b0;
		put_data = {attr_q, ch_q};
		case (ch_q)
			CH_NL: begin
				row_n = row_n + 1'b1;
				col_n = '0;
			end
			CH_TAB: begin
				col_n = (col_n + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
			end
			CH_BS: begin
				if (col_q != '0) begin
					col_n    = col_n - 1'b1;
					wcol     = col_q - 1'b1;
					put_we   = 1'b1;
					put_data = blank_attr;
				end
			end
			default: begin
				put_we = 1'b1;
				col_n  = col_n + 1'b1;
			end
		endcase
		if (col_n >= (COL_W+1)'(COLS)) begin
			row_n = row_n + 1'b1;
			col_n = '0;
		end
		scroll_need = (row_n >= (ROW_W+1)'(ROWS));
	end

	assign put_addr = CELL_W'(int'(row_q) * COLS + int'(wcol));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			scrolled_q <= 1'b0;
		end else begin
			if (cmd.accept)
				scrolled_q <= 1'b0;
			if (cmd.home) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.put_exec) begin
				if (scroll_need) begin
					row_q      <= ROW_W'(ROWS - 1);
					col_q      <= '0;
					scrolled_q <= 1'b1;
				end else begin
					row_q <= row_n[ROW_W-1:0];
					col_q <= col_n[COL_W-1:0];
				end
			end
		end
	end

	// sweep over all cells: blank (reset, clear) or copy up one row, blanking the last row (scroll).
	// Stage 1 reads the source cell, the next cycle writes the destination.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_act_q  <= 1'b1;
			sweep_init_q <= 1'b1;
			sweep_copy_q <= 1'b0;
			cnt_q        <= '0;
			wr_s1        <= 1'b0;
		end else begin
			wr_s1 <= sweep_act_q;
			if (cmd.sweep_start) begin
				sweep_act_q  <= 1'b1;
				sweep_init_q <= 1'b0;
				sweep_copy_q <= cmd.sweep_copy;
				cnt_q        <= '0;
			end else if (sweep_act_q) begin
				if (cnt_q == CELL_W'(NCELLS - 1))
					sweep_act_q <= 1'b0;
				else
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign cnt_copy = sweep_copy_q && (cnt_q < CELL_W'(NCELLS - COLS));
	assign src      = (CELL_W+1)'(cnt_q) + (CELL_W+1)'(COLS);

	always_ff @(posedge clk) begin
		dest_s1 <= cnt_q;
		copy_s1 <= cnt_copy;
	end

	assign idx_ok = (32'(idx_q) < NCELLS);
	assign rd_en  = sweep_act_q || cmd.rd_issue;

	always_comb begin
		if (sweep_act_q)
			raddr = cnt_copy ? src[CELL_W-1:0] : '0;
		else
			raddr = idx_ok ? CELL_W'(idx_q) : '0;
	end

	always_comb begin
		if (wr_s1) begin
			we    = 1'b1;
			waddr = dest_s1;
			wdata = copy_s1 ? rdata_q : blank_sweep;
		end else begin
			we    = cmd.put_exec && put_we;
			waddr = put_addr;
			wdata = put_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[raddr];
		if (we)
			mem[waddr] <= wdata;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_value <= (req_q == REQ_READ && idx_ok) ? rdata_q : '0;
			cursor_row <= CROW_W'(row_q);
			cursor_col <= CCOL_W'(col_q);
			scrolled   <= scrolled_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign stat.sweep_busy  = sweep_act_q || wr_s1;
	assign stat.scroll_need = scroll_need;
	assign stat.out_free    = !out_valid_q || out_ready;

endmodule
